FILE: rtl/sdpg_pkg.sv
// ---------------------------------------------------------------------------
// sdpg_pkg - shared definitions for the step/dir pulse generator
// field widths, register indexes, action codes and reset values
// ---------------------------------------------------------------------------
package sdpg_pkg;

  // fixed field widths
  localparam int ACTION_W     = 2;
  localparam int STEP_COUNT_W = 32;
  localparam int DELAY_W      = 16;
  localparam int PULSE_W      = 10;
  localparam int SETUP_W      = 10;
  localparam int STEPS_W      = 31;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  // parameter defaults
  localparam int POSITION_WIDTH_DEF = 32;
  localparam int PERIOD_WIDTH_DEF   = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_SETUP     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_DELAY = 2'd2;

  // configuration reset values
  localparam logic [PULSE_W-1:0] PULSE_WIDTH_RST   = 10'd5;
  localparam logic [SETUP_W-1:0] DIR_SETUP_RST     = 10'd5;
  localparam logic [DELAY_W-1:0] DEFAULT_DELAY_RST = 16'd1000;

  // largest step count a move can hold
  localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_HOME = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

endpackage

FILE: rtl/stepper_step_dir_pulse_generator.sv
// ---------------------------------------------------------------------------
// stepper_step_dir_pulse_generator - step/direction stepper pulse generator
// result: registered, valid in the cycle after its input transfer
// throughput: one input transfer per cycle, the result register is refilled
//   in the same cycle it is taken, so the input only stalls on a full,
//   stalled result register
// reset: synchronous active-low rst_n; driver disabled, idle, position zero,
//   registers back to their default values, result register empty
// ---------------------------------------------------------------------------
module stepper_step_dir_pulse_generator #(
  parameter int POSITION_WIDTH = sdpg_pkg::POSITION_WIDTH_DEF,
  parameter int PERIOD_WIDTH   = sdpg_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  // configuration write port
  input  logic                                  cfg_we,
  input  logic [sdpg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sdpg_pkg::CFG_DATA_W-1:0]       cfg_data,

  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sdpg_pkg::ACTION_W-1:0]         in_action,
  input  logic signed [sdpg_pkg::STEP_COUNT_W-1:0] in_step_count,
  input  logic [sdpg_pkg::DELAY_W-1:0]          in_step_delay_us,
  input  logic                                  in_home_forward,

  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_step_out,
  output logic                                  out_dir_out,
  output logic                                  out_enable_n,
  output logic                                  out_idle,
  output logic signed [POSITION_WIDTH-1:0]      out_position
);

  localparam int STEPS_W = sdpg_pkg::STEPS_W;
  localparam int PULSE_W = sdpg_pkg::PULSE_W;
  localparam int SETUP_W = sdpg_pkg::SETUP_W;
  localparam int DELAY_W = sdpg_pkg::DELAY_W;
  localparam int CNT_W   = sdpg_pkg::STEP_COUNT_W;

  // configuration registers
  logic [PULSE_W-1:0] pulse_width_r;
  logic [SETUP_W-1:0] dir_setup_r;
  logic [DELAY_W-1:0] default_delay_r;

  // run state
  logic                      running_r,   running_nxt;
  logic                      homing_r,    homing_nxt;
  logic                      fwd_r,       fwd_nxt;
  logic                      disabled_r,  disabled_nxt;
  logic [STEPS_W-1:0]        steps_r,     steps_nxt;
  logic [PERIOD_WIDTH-1:0]   period_r,    period_nxt;
  logic [PERIOD_WIDTH-1:0]   per_cnt_r,   per_cnt_nxt;
  logic [PULSE_W-1:0]        pulse_cnt_r, pulse_cnt_nxt;
  logic [SETUP_W-1:0]        setup_cnt_r, setup_cnt_nxt;
  logic [POSITION_WIDTH-1:0] pos_r,       pos_nxt;

  // result register
  logic out_valid_r;

  logic in_xfer;
  logic out_free;

  // the result register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign in_xfer  = in_valid && out_free;

  // ---- command decode helpers ----
  sdpg_pkg::action_t action;
  assign action = sdpg_pkg::action_t'(in_action);

  // move magnitude, most negative count saturates
  logic              cnt_neg;
  logic [CNT_W-1:0]  cnt_mag;
  logic [STEPS_W-1:0] move_steps;
  assign cnt_neg    = in_step_count[CNT_W-1];
  assign cnt_mag    = cnt_neg ? (CNT_W'(0) - CNT_W'(in_step_count)) : CNT_W'(in_step_count);
  assign move_steps = cnt_mag[CNT_W-1] ? sdpg_pkg::STEPS_MAX : cnt_mag[STEPS_W-1:0];

  // effective period: zero picks the default, fit to period width, zero means one
  logic [DELAY_W-1:0]              delay_sel;
  logic [DELAY_W+PERIOD_WIDTH-1:0] delay_wide;
  logic [PERIOD_WIDTH-1:0]         period_fit;
  logic [PERIOD_WIDTH-1:0]         period_load;
  assign delay_sel   = (in_step_delay_us == '0) ? default_delay_r : in_step_delay_us;
  assign delay_wide  = {{PERIOD_WIDTH{1'b0}}, delay_sel};
  assign period_fit  = delay_wide[PERIOD_WIDTH-1:0];
  assign period_load = (period_fit == '0) ? PERIOD_WIDTH'(1) : period_fit;

  // zero pulse width acts as one tick
  logic [PULSE_W-1:0] pulse_load;
  assign pulse_load = (pulse_width_r == '0) ? PULSE_W'(1) : pulse_width_r;

  // ---- tick datapath ----
  logic [PULSE_W-1:0]      pulse_dec;
  logic                    pulse_end;
  logic [STEPS_W-1:0]      steps_dec;
  logic                    move_done;
  logic [PERIOD_WIDTH-1:0] per_inc;
  logic [PULSE_W-1:0]      pulse_after;
  logic [POSITION_WIDTH-1:0] pos_step;

  assign pulse_dec   = pulse_cnt_r - PULSE_W'(1);
  assign pulse_end   = (pulse_cnt_r != '0) && (pulse_dec == '0);
  assign steps_dec   = (steps_r != '0) ? (steps_r - STEPS_W'(1)) : steps_r;
  assign move_done   = pulse_end && !homing_r && (steps_dec == '0);
  assign per_inc     = per_cnt_r + PERIOD_WIDTH'(1);
  assign pulse_after = (pulse_cnt_r != '0) ? pulse_dec : pulse_cnt_r;
  assign pos_step    = fwd_r ? (pos_r + POSITION_WIDTH'(1)) : (pos_r - POSITION_WIDTH'(1));

  always_comb begin
    running_nxt   = running_r;
    homing_nxt    = homing_r;
    fwd_nxt       = fwd_r;
    disabled_nxt  = disabled_r;
    steps_nxt     = steps_r;
    period_nxt    = period_r;
    per_cnt_nxt   = per_cnt_r;
    pulse_cnt_nxt = pulse_cnt_r;
    setup_cnt_nxt = setup_cnt_r;
    pos_nxt       = pos_r;

    case (action)
      sdpg_pkg::ACT_TICK: begin
        if (running_r) begin
          if (setup_cnt_r != '0) begin
            // direction setup still counting
            setup_cnt_nxt = setup_cnt_r - SETUP_W'(1);
          end else if (move_done) begin
            // last step of a move finished: halt and disable
            pos_nxt       = pos_step;
            running_nxt   = 1'b0;
            homing_nxt    = 1'b0;
            steps_nxt     = '0;
            per_cnt_nxt   = '0;
            pulse_cnt_nxt = '0;
            disabled_nxt  = 1'b1;
          end else begin
            pulse_cnt_nxt = pulse_after;
            if (pulse_end) begin
              pos_nxt = pos_step;
              if (!homing_r) begin
                steps_nxt = steps_dec;
              end
            end
            if (per_inc >= period_r) begin
              // period expired; a pulse still high swallows this step
              per_cnt_nxt = '0;
              if (pulse_after == '0) begin
                pulse_cnt_nxt = pulse_load;
              end
            end else begin
              per_cnt_nxt = per_inc;
            end
          end
        end
      end
      sdpg_pkg::ACT_MOVE: begin
        // zero count leaves any run alone
        if (in_step_count != '0) begin
          running_nxt   = 1'b1;
          homing_nxt    = 1'b0;
          fwd_nxt       = !cnt_neg;
          disabled_nxt  = 1'b0;
          steps_nxt     = move_steps;
          period_nxt    = period_load;
          per_cnt_nxt   = '0;
          pulse_cnt_nxt = '0;
          setup_cnt_nxt = dir_setup_r;
        end
      end
      sdpg_pkg::ACT_HOME: begin
        running_nxt   = 1'b1;
        homing_nxt    = 1'b1;
        fwd_nxt       = in_home_forward;
        disabled_nxt  = 1'b0;
        steps_nxt     = '0;
        period_nxt    = period_load;
        per_cnt_nxt   = '0;
        pulse_cnt_nxt = '0;
        setup_cnt_nxt = dir_setup_r;
      end
      default: begin
        // stop: cut any pulse, disable the driver, keep direction
        running_nxt   = 1'b0;
        homing_nxt    = 1'b0;
        steps_nxt     = '0;
        per_cnt_nxt   = '0;
        pulse_cnt_nxt = '0;
        setup_cnt_nxt = '0;
        disabled_nxt  = 1'b1;
      end
    endcase
  end

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_width_r   <= sdpg_pkg::PULSE_WIDTH_RST;
      dir_setup_r     <= sdpg_pkg::DIR_SETUP_RST;
      default_delay_r <= sdpg_pkg::DEFAULT_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sdpg_pkg::REG_PULSE_WIDTH:   pulse_width_r   <= cfg_data[PULSE_W-1:0];
        sdpg_pkg::REG_DIR_SETUP:     dir_setup_r     <= cfg_data[SETUP_W-1:0];
        sdpg_pkg::REG_DEFAULT_DELAY: default_delay_r <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // run state advances only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      homing_r    <= 1'b0;
      fwd_r       <= 1'b0;
      disabled_r  <= 1'b1;
      steps_r     <= '0;
      period_r    <= '0;
      per_cnt_r   <= '0;
      pulse_cnt_r <= '0;
      setup_cnt_r <= '0;
      pos_r       <= '0;
    end else if (in_xfer) begin
      running_r   <= running_nxt;
      homing_r    <= homing_nxt;
      fwd_r       <= fwd_nxt;
      disabled_r  <= disabled_nxt;
      steps_r     <= steps_nxt;
      period_r    <= period_nxt;
      per_cnt_r   <= per_cnt_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      setup_cnt_r <= setup_cnt_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // result register: pin levels after the item is applied
  logic                      step_q_r;
  logic                      dir_q_r;
  logic                      en_n_q_r;
  logic                      idle_q_r;
  logic [POSITION_WIDTH-1:0] pos_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      step_q_r <= (pulse_cnt_nxt != '0);
      dir_q_r  <= fwd_nxt;
      en_n_q_r <= disabled_nxt;
      idle_q_r <= !running_nxt;
      pos_q_r  <= pos_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_step_out = step_q_r;
  assign out_dir_out  = dir_q_r;
  assign out_enable_n = en_n_q_r;
  assign out_idle     = idle_q_r;
  assign out_position = signed'(pos_q_r);

endmodule
